FILE: rtl/lsa_pkg.sv
package lsa_pkg;

  localparam int CH_W   = 8;
  localparam int SAT_W  = 9;
  localparam int SQ_W   = 16;
  localparam int COEF_W = 10;
  localparam int X_W    = SQ_W + COEF_W;
  localparam int Y_W    = X_W - 3;
  localparam int SUM_W  = 16;
  localparam int RECIP_W = 24;
  localparam int PROD_W = Y_W + RECIP_W;

  // Luma weights in thousandths.
  localparam logic [COEF_W-1:0] COEF_RED   = 10'd241;
  localparam logic [COEF_W-1:0] COEF_GREEN = 10'd691;
  localparam logic [COEF_W-1:0] COEF_BLUE  = 10'd68;

  // Division by 1000 is a shift by 3 followed by a multiply with
  // ceil(2^30 / 125), exact for every value a term can reach.
  localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;
  localparam int RECIP_SHIFT = 30;

  localparam logic [SAT_W-1:0] SAT_GAIN_RESET = 9'd255;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            frame_end_in;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end_out;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [CH_W-1:0]  root;
    pixel_t           pix;
  } root_t;

endpackage

FILE: rtl/lsa_term.sv
module lsa_term (
  input  logic                      clk,
  input  logic                      en,
  input  logic [lsa_pkg::CH_W-1:0]   chan,
  input  logic [lsa_pkg::COEF_W-1:0] coef,
  output logic [lsa_pkg::SUM_W-1:0]  term
);
  import lsa_pkg::*;

  logic [SQ_W-1:0]   sq;
  logic [X_W-1:0]    x;
  logic [Y_W-1:0]    y;
  logic [PROD_W-1:0] prod;

  assign x    = X_W'(sq) * X_W'(coef);
  assign prod = PROD_W'(y) * PROD_W'(RECIP_125);

  always_ff @(posedge clk) begin
    if (en) begin
      sq   <= {{CH_W{1'b0}}, chan} * {{CH_W{1'b0}}, chan};
      y    <= x[X_W-1:3];
      term <= prod[RECIP_SHIFT +: SUM_W];
    end
  end

endmodule

FILE: rtl/lsa_root_cell.sv
module lsa_root_cell #(
  parameter int BIT_POS = 7
) (
  input  logic            clk,
  input  logic            en,
  input  lsa_pkg::root_t  din,
  output lsa_pkg::root_t  dout
);
  import lsa_pkg::*;

  localparam int T_W = SUM_W + 1;

  logic [T_W-1:0] trial;
  logic           take;
  root_t          step;

  // Adding this bit to the root raises its square by root*2^(k+1) + 2^(2k).
  assign trial = (T_W'(din.root) << (BIT_POS + 1)) + (T_W'(1) << (2 * BIT_POS));
  assign take  = {1'b0, din.rem} >= trial;

  always_comb begin
    step = din;
    if (take) begin
      step.rem  = din.rem - trial[SUM_W-1:0];
      step.root = din.root | (CH_W'(1) << BIT_POS);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= step;
    end
  end

endmodule

FILE: rtl/lsa_mix.sv
module lsa_mix (
  input  logic                     clk,
  input  logic                     en,
  input  logic [lsa_pkg::SAT_W-1:0] sat_gain,
  input  logic [lsa_pkg::CH_W-1:0]  luma,
  input  lsa_pkg::pixel_t           pix,
  output lsa_pkg::result_t          res
);
  import lsa_pkg::*;

  localparam int INV_W  = SAT_W + 1;
  localparam int ISP_W  = INV_W + CH_W + 1;
  localparam int CP_W   = SAT_W + CH_W;
  localparam int ACC_W  = 12;

  logic signed [INV_W-1:0] inv;
  logic signed [ISP_W-1:0] isp_prod;
  logic [CP_W-1:0]         red_prod;
  logic [CP_W-1:0]         green_prod;
  logic [CP_W-1:0]         blue_prod;
  logic                    frame_end;

  logic signed [ACC_W-1:0] isp;
  logic signed [ACC_W-1:0] red_acc;
  logic signed [ACC_W-1:0] green_acc;
  logic signed [ACC_W-1:0] blue_acc;

  function automatic logic [CH_W-1:0] clamp_byte(input logic signed [ACC_W-1:0] v);
    logic [CH_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > ACC_W'(255)) begin
      r = '1;
    end else begin
      r = v[CH_W-1:0];
    end
    return r;
  endfunction

  assign inv = $signed(INV_W'(255)) - $signed({1'b0, sat_gain});

  // The arithmetic shift floors negative products.
  assign isp       = ACC_W'(isp_prod >>> 8);
  assign red_acc   = isp + $signed(ACC_W'(red_prod[CP_W-1:8]));
  assign green_acc = isp + $signed(ACC_W'(green_prod[CP_W-1:8]));
  assign blue_acc  = isp + $signed(ACC_W'(blue_prod[CP_W-1:8]));

  always_ff @(posedge clk) begin
    if (en) begin
      isp_prod   <= ISP_W'(inv) * $signed({{(ISP_W-CH_W){1'b0}}, luma});
      red_prod   <= CP_W'(sat_gain) * CP_W'(pix.red_in);
      green_prod <= CP_W'(sat_gain) * CP_W'(pix.green_in);
      blue_prod  <= CP_W'(sat_gain) * CP_W'(pix.blue_in);
      frame_end  <= pix.frame_end_in;

      res.red_out       <= clamp_byte(red_acc);
      res.green_out     <= clamp_byte(green_acc);
      res.blue_out      <= clamp_byte(blue_acc);
      res.frame_end_out <= frame_end;
    end
  end

endmodule

FILE: rtl/luma_saturation_adjust.sv
// Saturation adjustment on an RGB pixel stream, one pixel per beat.
// The pixel channel (pixel_valid, pixel_stall, pixel) takes red, green,
// blue and a frame-end mark; the result channel (result_valid,
// result_stall, result) returns the adjusted channels and the same mark.
// sat_gain is written through cfg_write/cfg_wdata while the stream is idle;
// the user must keep to this, the block does not enforce it. 255 scales each
// channel by 255/256 (rounded down), 0 gives grey, larger values boost.
// An accepted pixel passes the luma term registers (square, weighted, divided),
// a sum register, eight root cells (one result bit per cell) and mix and clamp registers.
// Throughput is one pixel per cycle unless a result stalls; the whole pipeline advances together.
// When result_stall holds a waiting result, the pipeline freezes and
// pixel_stall is raised in the same cycle, so nothing is dropped.
// Reset empties the pipeline and sets sat_gain to 255.
module luma_saturation_adjust (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [lsa_pkg::SAT_W-1:0] cfg_wdata,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  lsa_pkg::pixel_t           pixel,
  output logic                      result_valid,
  input  logic                      result_stall,
  output lsa_pkg::result_t          result
);
  import lsa_pkg::*;

  localparam int FRONT = 4;
  localparam int CELLS = CH_W;
  localparam int LAT   = FRONT + CELLS + 2;

  logic             en;
  logic [LAT-1:0]   vld;
  logic [SAT_W-1:0] sat_gain;

  logic [SUM_W-1:0] term_red;
  logic [SUM_W-1:0] term_green;
  logic [SUM_W-1:0] term_blue;
  logic [SUM_W-1:0] luma_sq;
  pixel_t           pix_pipe [FRONT];
  root_t            chain [CELLS+1];

  assign en           = !(result_valid && result_stall);
  assign pixel_stall  = !en;
  assign result_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      sat_gain <= SAT_GAIN_RESET;
    end else begin
      if (en) begin
        vld <= {vld[LAT-2:0], pixel_valid};
      end
      if (cfg_write) begin
        sat_gain <= cfg_wdata;
      end
    end
  end

  lsa_term u_term_red (
    .clk (clk), .en (en), .chan (pixel.red_in), .coef (COEF_RED), .term (term_red)
  );
  lsa_term u_term_green (
    .clk (clk), .en (en), .chan (pixel.green_in), .coef (COEF_GREEN), .term (term_green)
  );
  lsa_term u_term_blue (
    .clk (clk), .en (en), .chan (pixel.blue_in), .coef (COEF_BLUE), .term (term_blue)
  );

  // The weighted sum stays below 2^16, so the top carry bits are always zero.
  always_ff @(posedge clk) begin
    if (en) begin
      pix_pipe[0] <= pixel;
      for (int i = 1; i < FRONT; i++) begin
        pix_pipe[i] <= pix_pipe[i-1];
      end
      luma_sq <= SUM_W'(({2'b00, term_red} + {2'b00, term_green}) + {2'b00, term_blue});
    end
  end

  assign chain[0].rem  = luma_sq;
  assign chain[0].root = '0;
  assign chain[0].pix  = pix_pipe[FRONT-1];

  for (genvar i = 0; i < CELLS; i++) begin : g_root
    lsa_root_cell #(
      .BIT_POS (CELLS - 1 - i)
    ) u_cell (
      .clk  (clk),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  lsa_mix u_mix (
    .clk      (clk),
    .en       (en),
    .sat_gain (sat_gain),
    .luma     (chain[CELLS].root),
    .pix      (chain[CELLS].pix),
    .res      (result)
  );

endmodule

FILE: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lsa_pkg::*;

  localparam int QUIET_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_PIXELS  = 210;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [SAT_W-1:0] cfg_wdata = '0;
  logic             pixel_valid = 1'b0;
  logic             pixel_stall;
  pixel_t           pixel = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;

  pixel_t           pending_pixels[$];
  result_t          adjusted_pixels[$];
  logic [SAT_W-1:0] gain_now = SAT_GAIN_RESET;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               error_count = 0;
  int               quiet_cycles = 0;

  luma_saturation_adjust dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_wdata    (cfg_wdata),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [CH_W-1:0] to_byte(int v);
    if (v < 0) return '0;
    if (v > 255) return 8'hff;
    return v[CH_W-1:0];
  endfunction

  // Perceived brightness: floor root of the three weighted squares, each
  // term truncated to whole thousandths on its own.
  function automatic int luma_of(pixel_t px);
    int r, g, b, luma_sq, luma;
    r = int'(px.red_in);
    g = int'(px.green_in);
    b = int'(px.blue_in);
    luma_sq = (r * r * int'(COEF_RED)) / 1000 + (g * g * int'(COEF_GREEN)) / 1000
            + (b * b * int'(COEF_BLUE)) / 1000;
    luma = 0;
    while ((luma + 1) * (luma + 1) <= luma_sq) luma++;
    return luma;
  endfunction

  function automatic result_t adjust_pixel(pixel_t px, logic [SAT_W-1:0] gain);
    int      s, shade;
    result_t res;
    s = int'(gain);
    // The inverse gain goes negative above 255; the shift must floor.
    shade = ((255 - s) * luma_of(px)) >>> 8;
    res.red_out       = to_byte(shade + ((s * int'(px.red_in)) >>> 8));
    res.green_out     = to_byte(shade + ((s * int'(px.green_in)) >>> 8));
    res.blue_out      = to_byte(shade + ((s * int'(px.blue_in)) >>> 8));
    res.frame_end_out = px.frame_end_in;
    return res;
  endfunction

  function automatic pixel_t make_pixel(int r, int g, int b, bit fe);
    pixel_t px;
    px.red_in       = r[CH_W-1:0];
    px.green_in     = g[CH_W-1:0];
    px.blue_in      = b[CH_W-1:0];
    px.frame_end_in = fe;
    return px;
  endfunction

  // Channels lean toward 0 and 255 now and then so that both clamps get hit.
  function automatic logic [CH_W-1:0] random_channel();
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return '0;
    if (pick == 1) return 8'hff;
    return CH_W'($urandom_range(255));
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px.red_in       = random_channel();
    px.green_in     = random_channel();
    px.blue_in      = random_channel();
    px.frame_end_in = ($urandom_range(7) == 0);
    return px;
  endfunction

  task automatic push_corner_pixels();
    pending_pixels.push_back(make_pixel(0, 0, 0, 1'b0));
    pending_pixels.push_back(make_pixel(255, 255, 255, 1'b1));
    pending_pixels.push_back(make_pixel(255, 0, 0, 1'b0));
    pending_pixels.push_back(make_pixel(0, 255, 0, 1'b0));
    pending_pixels.push_back(make_pixel(0, 0, 255, 1'b1));
    pending_pixels.push_back(make_pixel(1, 254, 128, 1'b0));
    pending_pixels.push_back(make_pixel(255, 255, 0, 1'b1));
    pending_pixels.push_back(make_pixel(0, 1, 2, 1'b0));
  endtask

  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_pixels.size() != 0 || pixel_valid || adjusted_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(logic [SAT_W-1:0] gain);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= gain;
    @(posedge clk);
    cfg_write <= 1'b0;
    gain_now = gain;
  endtask

  task automatic compare_field(string field, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // Pixel side: the prediction is taken on the beat that the block accepts.
  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall)
        adjusted_pixels.push_back(adjust_pixel(pixel, gain_now));
      if (!pixel_valid || !pixel_stall) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel       <= pending_pixels.pop_front();
          pixel_valid <= 1'b1;
        end else begin
          pixel_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (adjusted_pixels.size() == 0) begin
          error_count++;
          $display("%0t: result beat with nothing expected, got %p", $time, result);
        end else begin
          want = adjusted_pixels.pop_front();
          compare_field("red", want.red_out, result.red_out);
          compare_field("green", want.green_out, result.green_out);
          compare_field("blue", want.blue_out, result.blue_out);
          compare_field("frame_end", CH_W'(want.frame_end_out),
                        CH_W'(result.frame_end_out));
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [SAT_W-1:0] phase_gains [RANDOM_PHASES];
    int               phase;
    phase_gains[0] = 9'd0;
    phase_gains[1] = 9'd511;
    phase_gains[2] = 9'd256;
    phase_gains[3] = 9'd1;
    phase_gains[4] = 9'd254;
    phase_gains[5] = 9'd510;
    phase_gains[6] = SAT_W'($urandom_range(511));
    phase_gains[7] = SAT_W'($urandom_range(511));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Corner pixels at the reset gain, at full boost, and at full grey.
    push_corner_pixels();
    wait_until_idle();
    write_gain(9'd511);
    push_corner_pixels();
    wait_until_idle();
    write_gain(9'd0);
    push_corner_pixels();
    wait_until_idle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      write_gain(phase_gains[phase]);
      repeat (PHASE_PIXELS) pending_pixels.push_back(random_pixel());
      wait_until_idle();
    end

    if (error_count == 0 && adjusted_pixels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lsa_pkg.sv
rtl/lsa_term.sv
rtl/lsa_root_cell.sv
rtl/lsa_mix.sv
rtl/luma_saturation_adjust.sv
bench/testbench.sv
